[rtl/spq_pkg.sv]
// Package for the sorted priority queue: entry type, cell control struct,
// request and status codes. No dependencies.
`default_nettype none

package spq_pkg;

  localparam int WordW  = 32;
  localparam int PrioW  = 8;
  localparam int CountW = 5;

  typedef struct packed {
    logic signed [WordW-1:0] word_a;
    logic signed [WordW-1:0] word_b;
    logic signed [WordW-1:0] word_c;
    logic        [PrioW-1:0] prio;
  } spq_entry_t;

  // broadcast to every cell in the chain
  typedef struct packed {
    logic ins;
    logic rem;
  } spq_ctrl_t;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } spq_status_t;

endpackage : spq_pkg

`default_nettype wire

[rtl/spq_cell.sv]
// One slot of the sorted chain: holds an entry, compares it with the new
// entry; takes it or the left or right neighbour's. Depends on spq_pkg.
`default_nettype none

module spq_cell
  import spq_pkg::*;
(
  input  wire        clk,
  input  spq_ctrl_t  ctrl,
  input  spq_entry_t new_entry,
  input  wire        occupied,
  input  wire        left_ge,
  input  spq_entry_t left_entry,
  input  spq_entry_t right_entry,
  output logic       ge,
  output spq_entry_t slot
);

  spq_entry_t slot_r;
  spq_entry_t slot_nxt;

  // this slot stays ahead of the new entry
  assign ge   = occupied && (slot_r.prio >= new_entry.prio);
  assign slot = slot_r;

  always_comb begin
    slot_nxt = slot_r;
    priority if (ctrl.ins) begin
      if (ge) begin
        slot_nxt = slot_r;
      end else if (left_ge) begin
        slot_nxt = new_entry;
      end else begin
        slot_nxt = left_entry;
      end
    end else if (ctrl.rem) begin
      slot_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
  end

endmodule : spq_cell

`default_nettype wire

[rtl/sorted_priority_queue_top.sv]
// Top level of the sorted priority queue: entry count, row of spq_cell
// slots and the result register. Depends on spq_pkg and spq_cell.
//
//  channel  | handshake           | fields
//  ---------+---------------------+------------------------------------------
//  request  | start / busy        | in_req_type, in_word_a..c, in_priority
//  result   | out_valid (strobe)  | out_word_a..c, out_priority, out_status, out_count_after
//
// One transaction a cycle: every slot cell updates in the cycle of
// acceptance, and the result strobe is registered and follows in the next
// cycle. This rate rests on the compare-and-shift in each cell.
// busy is high only while rst_n is low. Reset clears the entry count and the
// strobe; slot contents are left as they are. The receiver cannot stall.
`default_nettype none

module sorted_priority_queue_top
  import spq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     start,
  output logic                    busy,
  input  wire                     in_req_type,
  input  wire signed [WordW-1:0]  in_word_a,
  input  wire signed [WordW-1:0]  in_word_b,
  input  wire signed [WordW-1:0]  in_word_c,
  input  wire        [PrioW-1:0]  in_priority,
  output logic                    out_valid,
  output logic signed [WordW-1:0] out_word_a,
  output logic signed [WordW-1:0] out_word_b,
  output logic signed [WordW-1:0] out_word_c,
  output logic       [PrioW-1:0]  out_priority,
  output logic       [1:0]        out_status,
  output logic       [CountW-1:0] out_count_after
);

  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0] count_r, count_nxt;
  logic          valid_r;
  spq_entry_t    res_r, res_nxt;
  spq_status_t   status_r, status_nxt;

  spq_entry_t    new_entry;
  spq_ctrl_t     ctrl;
  spq_entry_t    slot [DEPTH];
  logic          ge   [DEPTH];
  logic          occ  [DEPTH];
  logic          accept, full, empty;
  logic [CW+CountW-1:0] count_ext;

  assign busy   = ~rst_n;
  assign accept = start && !busy;
  assign full   = (count_r == CW'(DEPTH));
  assign empty  = (count_r == '0);

  assign new_entry = '{word_a: in_word_a, word_b: in_word_b,
                       word_c: in_word_c, prio: in_priority};

  assign ctrl.ins = accept && (in_req_type == REQ_INSERT) && !full;
  assign ctrl.rem = accept && (in_req_type == REQ_REMOVE) && !empty;

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      spq_entry_t left_e, right_e;
      logic       left_g;

      assign occ[gi] = (CW'(gi) < count_r);

      if (gi == 0) begin : g_head
        assign left_e = new_entry;
        assign left_g = 1'b1;
      end else begin : g_mid
        assign left_e = slot[gi-1];
        assign left_g = ge[gi-1];
      end

      if (gi == DEPTH - 1) begin : g_tail
        assign right_e = slot[gi];
      end else begin : g_body
        assign right_e = slot[gi+1];
      end

      spq_cell u_cell (
        .clk         (clk),
        .ctrl        (ctrl),
        .new_entry   (new_entry),
        .occupied    (occ[gi]),
        .left_ge     (left_g),
        .left_entry  (left_e),
        .right_entry (right_e),
        .ge          (ge[gi]),
        .slot        (slot[gi])
      );
    end
  endgenerate

  always_comb begin
    count_nxt  = count_r;
    res_nxt    = '0;
    status_nxt = ST_DONE;
    if (accept) begin
      unique case (in_req_type)
        REQ_INSERT: begin
          if (full) begin
            status_nxt = ST_FULL;
          end else begin
            count_nxt = count_r + CW'(1);
          end
        end
        REQ_REMOVE: begin
          if (empty) begin
            status_nxt = ST_EMPTY;
          end else begin
            res_nxt   = slot[0];
            count_nxt = count_r - CW'(1);
          end
        end
        default: status_nxt = ST_DONE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      valid_r <= accept;
    end
  end

  // result payload: no reset needed
  always_ff @(posedge clk) begin
    res_r    <= res_nxt;
    status_r <= status_nxt;
  end

  assign count_ext       = {{CountW{1'b0}}, count_r};
  assign out_valid       = valid_r;
  assign out_word_a      = res_r.word_a;
  assign out_word_b      = res_r.word_b;
  assign out_word_c      = res_r.word_c;
  assign out_priority    = res_r.prio;
  assign out_status      = status_r;
  assign out_count_after = count_ext[CountW-1:0];

endmodule : sorted_priority_queue_top

`default_nettype wire

[rtl/spq_checker.sv]
// Port-level checker for sorted_priority_queue_top and its bind statement.
// Depends on spq_pkg.
`default_nettype none

module spq_checker
  import spq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input wire                    clk,
  input wire                    rst_n,
  input wire                    start,
  input wire                    busy,
  input wire                    in_req_type,
  input wire                    out_valid,
  input wire signed [WordW-1:0] out_word_a,
  input wire       [PrioW-1:0]  out_priority,
  input wire       [1:0]        out_status,
  input wire       [CountW-1:0] out_count_after
);

  // every accepted transaction strobes exactly one result next cycle
  a_strobe_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> out_valid)
    else $error("result strobe missing after accepted transaction");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |=> !out_valid)
    else $error("result strobe without accepted transaction");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_DONE) |-> (out_word_a == '0 && out_priority == '0))
    else $error("failed transaction carried payload");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_EMPTY) |-> (out_count_after == '0))
    else $error("empty status with non-zero count");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_req_type == REQ_INSERT) ##1 (out_valid && out_status == ST_FULL)
      |-> (out_count_after == CountW'(DEPTH)))
    else $error("full status with wrong count");

endmodule : spq_checker

bind sorted_priority_queue_top spq_checker #(.DEPTH(DEPTH)) u_spq_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .in_req_type     (in_req_type),
  .out_valid       (out_valid),
  .out_word_a      (out_word_a),
  .out_priority    (out_priority),
  .out_status      (out_status),
  .out_count_after (out_count_after)
);

`default_nettype wire
